>>> rtl/core/pse_pkg.sv
`default_nettype none
package pse_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned WordW = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_POW = 4'd4,
    OP_MOD = 4'd5, OP_GT = 4'd6, OP_LT = 4'd7, OP_GE = 4'd8, OP_LE = 4'd9,
    OP_NE = 4'd10, OP_EQ = 4'd11, OP_NOT = 4'd12, OP_AND = 4'd13, OP_OR = 4'd14,
    OP_NONE = 4'd15
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POP_B, ST_WAIT_B, ST_POP_A, ST_WAIT_A, ST_EXEC, ST_ITER,
    ST_PUSH, ST_LAST, ST_WAIT_T, ST_EMIT, ST_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_token;   // capture the input request
    logic push_val;     // push the captured operand
    logic pop_b;        // start a read of the top entry into b
    logic pop_a;        // start a read of the top entry into a
    logic take_b;       // latch read data into b
    logic take_a;       // latch read data into a
    logic exec_start;   // set up the operation
    logic iter_step;    // one divide or power step
    logic push_res;     // push the operation result
    logic emit;         // form the result item
    logic clear;        // clear stack pointer and error
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_operand;
    logic is_not;
    logic is_none;
    logic iter_done;
    logic need_iter;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/pse_ctrl.sv
`default_nettype none
module pse_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic          in_last,
  input  wire logic          out_free,
  input  wire pse_pkg::sts_t sts,
  output pse_pkg::cmd_t      cmd,
  output logic               idle
);

  pse_pkg::state_t state, state_next;
  logic last_q;

  // Hold the state and the last marker of the request
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pse_pkg::ST_IDLE;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) last_q <= in_last;
    end
  end

  // Sequence one request
  always_comb begin
    cmd        = '0;
    state_next = state;
    idle       = 1'b0;
    case (state)
      pse_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load_token = 1'b1;
          state_next = pse_pkg::ST_POP_B;
        end
      end
      pse_pkg::ST_POP_B: begin
        if (sts.is_operand) begin
          cmd.push_val = 1'b1;
          state_next = pse_pkg::ST_LAST;
        end else if (sts.is_none) begin
          state_next = pse_pkg::ST_LAST;
        end else begin
          cmd.pop_b = 1'b1;
          state_next = pse_pkg::ST_WAIT_B;
        end
      end
      pse_pkg::ST_WAIT_B: begin
        cmd.take_b = 1'b1;
        state_next = sts.is_not ? pse_pkg::ST_EXEC : pse_pkg::ST_POP_A;
      end
      pse_pkg::ST_POP_A: begin
        cmd.pop_a = 1'b1;
        state_next = pse_pkg::ST_WAIT_A;
      end
      pse_pkg::ST_WAIT_A: begin
        cmd.take_a = 1'b1;
        state_next = pse_pkg::ST_EXEC;
      end
      pse_pkg::ST_EXEC: begin
        cmd.exec_start = 1'b1;
        state_next = sts.need_iter ? pse_pkg::ST_ITER : pse_pkg::ST_PUSH;
      end
      pse_pkg::ST_ITER: begin
        cmd.iter_step = 1'b1;
        if (sts.iter_done) state_next = pse_pkg::ST_PUSH;
      end
      pse_pkg::ST_PUSH: begin
        cmd.push_res = 1'b1;
        state_next = pse_pkg::ST_LAST;
      end
      pse_pkg::ST_LAST: begin
        if (last_q) begin
          cmd.pop_b = 1'b1;
          state_next = pse_pkg::ST_WAIT_T;
        end else begin
          state_next = pse_pkg::ST_IDLE;
        end
      end
      pse_pkg::ST_WAIT_T: state_next = pse_pkg::ST_EMIT;
      pse_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          cmd.clear = 1'b1;
          state_next = pse_pkg::ST_IDLE;
        end
      end
      default: state_next = pse_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/pse_dp.sv
`default_nettype none
module pse_dp #(
  parameter int unsigned STACK_DEPTH = pse_pkg::StackDepth
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_type,
  input  wire logic [pse_pkg::WordW-1:0]  operand_value,
  input  wire logic [3:0]                 op_code,
  input  wire pse_pkg::cmd_t              cmd,
  output pse_pkg::sts_t                   sts,
  output logic [pse_pkg::WordW-1:0]       result_value,
  output logic                            eval_ok,
  output logic                            has_value
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_data;
  logic        rd_en;
  logic        rd_hit;        // read was from a nonempty stack
  logic [PW-1:0] sp;
  logic        err;
  logic        kind;
  logic [31:0] val;
  logic [3:0]  op;
  logic [31:0] a, b;
  logic [31:0] res;
  logic        res_ok;
  // iterative unit state
  logic [31:0] acc, base, expo;
  logic [31:0] rem, quo, dvs;
  logic        neg_q, neg_r;
  logic [5:0]  cnt;
  logic        wr_en;
  logic [31:0] wr_data;
  logic [AW-1:0] wr_addr;

  assign sts.is_operand = (kind == 1'b0);
  assign sts.is_not     = (op == pse_pkg::OP_NOT);
  assign sts.is_none    = (kind == 1'b1) && (op == pse_pkg::OP_NONE);
  assign sts.need_iter  = ((op == pse_pkg::OP_DIV) || (op == pse_pkg::OP_MOD)) && (b != 0)
                          || ((op == pse_pkg::OP_POW) && !b[31]);
  assign sts.iter_done  = (cnt == 6'd31);

  // Stack memory write and registered read
  assign rd_en = cmd.pop_a || cmd.pop_b;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[AW'(sp - PW'(1))];
  end

  assign wr_en   = (cmd.push_val || (cmd.push_res && res_ok)) && (sp != FULL);
  assign wr_data = cmd.push_val ? val : res;
  assign wr_addr = AW'(sp);

  // Stack pointer, error flag, token and operand capture
  always_ff @(posedge clk) begin
    if (rst) begin
      sp  <= '0;
      err <= 1'b0;
    end else begin
      if (cmd.clear) begin
        sp  <= '0;
        err <= 1'b0;
      end else begin
        if (rd_en && sp != '0) sp <= sp - PW'(1);
        if (wr_en) sp <= sp + PW'(1);
        if ((cmd.push_val || (cmd.push_res && res_ok)) && sp == FULL) err <= 1'b1;
        if (cmd.push_res && !res_ok) err <= 1'b1;
      end
    end
    if (rd_en) rd_hit <= (sp != '0);
    if (cmd.load_token) begin
      kind <= req_type;
      val  <= operand_value;
      op   <= op_code;
    end
    if (cmd.take_b) begin
      b <= rd_hit ? rd_data : 32'd0;
      a <= 32'd0;
    end
    if (cmd.take_a) a <= rd_hit ? rd_data : 32'd0;
  end

  // Divide (restoring, on magnitudes) and power (square and multiply)
  always_ff @(posedge clk) begin
    logic [32:0] trial;
    if (cmd.exec_start) begin
      cnt   <= '0;
      acc   <= 32'd1;
      base  <= a;
      expo  <= b;
      rem   <= '0;
      quo   <= a[31] ? -a : a;
      dvs   <= b[31] ? -b : b;
      neg_q <= a[31] ^ b[31];
      neg_r <= a[31];
    end else if (cmd.iter_step) begin
      cnt <= cnt + 6'd1;
      if (op == pse_pkg::OP_POW) begin
        if (expo[0]) acc <= acc * base;
        base <= base * base;
        expo <= expo >> 1;
      end else begin
        trial = {rem, quo[31]} - {1'b0, dvs};
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
      end
    end
  end

  // Operation result
  always_comb begin
    logic signed [31:0] sa, sb;
    sa = a;
    sb = b;
    res    = 32'd0;
    res_ok = 1'b1;
    case (op)
      pse_pkg::OP_ADD: res = a + b;
      pse_pkg::OP_SUB: res = a - b;
      pse_pkg::OP_MUL: res = a * b;
      pse_pkg::OP_DIV: begin
        res_ok = (b != 0);
        res = neg_q ? -quo : quo;
      end
      pse_pkg::OP_MOD: begin
        res_ok = (b != 0);
        res = neg_r ? -rem : rem;
      end
      pse_pkg::OP_POW: begin
        if (b[31]) begin
          res_ok = (a != 0);
          if (a == 32'd1) res = 32'd1;
          else if (a == 32'hFFFF_FFFF) res = b[0] ? 32'hFFFF_FFFF : 32'd1;
          else res = 32'd0;
        end else begin
          res = acc;
        end
      end
      pse_pkg::OP_GT:  res = {31'd0, sa > sb};
      pse_pkg::OP_LT:  res = {31'd0, sa < sb};
      pse_pkg::OP_GE:  res = {31'd0, sa >= sb};
      pse_pkg::OP_LE:  res = {31'd0, sa <= sb};
      pse_pkg::OP_NE:  res = {31'd0, a != b};
      pse_pkg::OP_EQ:  res = {31'd0, a == b};
      pse_pkg::OP_NOT: res = {31'd0, b == 0};
      pse_pkg::OP_AND: res = {31'd0, (a != 0) && (b != 0)};
      default:         res = {31'd0, (a != 0) || (b != 0)};
    endcase
  end

  // Result item, latched on emit
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_value <= rd_hit ? rd_data : 32'd0;
      has_value    <= rd_hit;
      eval_ok      <= !err;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/postfix_stack_evaluator_top.sv
// Postfix expression evaluator on an operand stack.
// Input channel s_axis: one token per request. tdata = {req_type, operand_value, op_code}
// from bit 0 up, tlast marks the final token of an expression.
// Output channel m_axis: one request per expression, after its final token.
// tdata = {result_value, eval_ok, has_value} from bit 0 up.
// Tokens are handled one at a time; s_axis_tready is high only while the
// controller waits for a token. Divide, modulo and power, bar a zero divisor
// or a negative exponent, run through the 32 steps of the shared
// shift-subtract / square-and-multiply unit. A final token also waits for
// the output register to drain.
// The result sits in an output register; the next expression's tokens are
// accepted while it waits for m_axis_tready. If a second result is ready
// before the first is taken, the block holds until the register is free.
// Reset clears the stack pointer, the error flag and the output valid; the
// stack memory needs no clearing, as only pushed entries are read.
`default_nettype none
module postfix_stack_evaluator_top #(
  parameter int unsigned STACK_DEPTH = pse_pkg::StackDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // req_type, operand_value, op_code, pad
  input  wire logic        s_axis_tlast,   // last_token
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // result_value, eval_ok, has_value, pad
);

  pse_pkg::cmd_t cmd;
  pse_pkg::sts_t sts;
  logic idle, in_fire, out_free;
  logic [31:0] result_value;
  logic eval_ok, has_value;

  assign s_axis_tready = idle;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  pse_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_last(s_axis_tlast),
    .out_free(out_free), .sts(sts), .cmd(cmd), .idle(idle)
  );

  pse_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst),
    .req_type(s_axis_tdata[0]), .operand_value(s_axis_tdata[32:1]),
    .op_code(s_axis_tdata[36:33]), .cmd(cmd), .sts(sts),
    .result_value(result_value), .eval_ok(eval_ok), .has_value(has_value)
  );

  // Output valid: set on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.emit) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  assign m_axis_tdata = {6'd0, has_value, eval_ok, result_value};

endmodule
`default_nettype wire

>>> rtl/core/pse_checker.sv
`default_nettype none
module pse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  // Output request holds while stalled
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request dropped or changed under stall");

  // No token is taken in the cycle right after one is taken
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("token accepted back to back");

  // An empty result reads as zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[33] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("empty result with nonzero value");

  // Output appears only after a final token
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !$rose(m_axis_tvalid))
    else $error("result without final token");

endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

>>> tb/pse_result_checker.sv
`default_nettype none
module pse_result_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // req_type, operand_value, op_code, pad
  input  wire logic        s_axis_tlast,   // last_token
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,   // result_value, eval_ok, has_value, pad
  output int               fail_count,
  output int               results_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pse_pkg::*;

  typedef struct packed {
    logic        has_value;
    logic        eval_ok;
    logic [31:0] value;
  } eval_result_t;

  logic [31:0]  shadow_stack [StackDepth];
  int unsigned  shadow_sp;
  logic         shadow_err;
  eval_result_t expected_results [$];

  assign results_pending = expected_results.size();

  function automatic logic [31:0] pop_shadow();
    if (shadow_sp == 0) return 32'd0;
    shadow_sp--;
    return shadow_stack[shadow_sp];
  endfunction

  function automatic void push_shadow(logic [31:0] v);
    if (shadow_sp >= StackDepth) begin
      shadow_err = 1'b1;
      return;
    end
    shadow_stack[shadow_sp] = v;
    shadow_sp++;
  endfunction

  // Apply one binary operator; return 0 when the result is undefined
  function automatic bit apply_op(op_t op, logic [31:0] a, logic [31:0] b,
                                  output logic [31:0] r);
    logic signed [31:0] sa, sb;
    logic [31:0] acc, base, e;
    sa = a;
    sb = b;
    r = 32'd0;
    case (op)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      OP_DIV: begin
        if (b == 0) return 0;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r = a;
        else r = sa / sb;
      end
      OP_MOD: begin
        if (b == 0) return 0;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r = 32'd0;
        else r = sa % sb;
      end
      OP_POW: begin
        if (sb < 0) begin
          if (a == 0) return 0;
          if (a == 32'd1) r = 32'd1;
          else if (a == 32'hFFFF_FFFF) r = b[0] ? 32'hFFFF_FFFF : 32'd1;
          else r = 32'd0;
        end else begin
          acc = 32'd1;
          base = a;
          e = b;
          for (int i = 0; i < 32; i++) begin
            if (e[0]) acc = acc * base;
            base = base * base;
            e = e >> 1;
          end
          r = acc;
        end
      end
      OP_GT: r = 32'(sa > sb);
      OP_LT: r = 32'(sa < sb);
      OP_GE: r = 32'(sa >= sb);
      OP_LE: r = 32'(sa <= sb);
      OP_NE: r = 32'(a != b);
      OP_EQ: r = 32'(a == b);
      OP_AND: r = 32'((a != 0) && (b != 0));
      default: r = 32'((a != 0) || (b != 0));
    endcase
    return 1;
  endfunction

  // Advance the shadow stack by one accepted token
  function automatic void eval_token(logic [39:0] tdata, logic last);
    logic [31:0] a, b, r;
    op_t op;
    eval_result_t res;
    op = op_t'(tdata[36:33]);
    if (!tdata[0]) begin
      push_shadow(tdata[32:1]);
    end else if (op == OP_NOT) begin
      a = pop_shadow();
      push_shadow(a == 0 ? 32'd1 : 32'd0);
    end else if (op != OP_NONE) begin
      b = pop_shadow();
      a = pop_shadow();
      if (apply_op(op, a, b, r)) push_shadow(r);
      else shadow_err = 1'b1;
    end
    if (last) begin
      res.has_value = (shadow_sp != 0);
      res.value = res.has_value ? pop_shadow() : 32'd0;
      res.eval_ok = !shadow_err;
      expected_results.push_back(res);
      shadow_sp = 0;
      shadow_err = 1'b0;
    end
  endfunction

  // Predict on each request and compare each result
  always @(posedge clk) begin
    eval_result_t got, exp_res;
    if (rst) begin
      shadow_sp = 0;
      shadow_err = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) eval_token(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[33:0];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (got.value !== exp_res.value)
            begin
              $display("%0t: result_value expected %h actual %h", $time,
                       exp_res.value, got.value);
              fail_count++;
            end
          if (got.eval_ok !== exp_res.eval_ok) begin
            $display("%0t: eval_ok expected %b actual %b", $time,
                     exp_res.eval_ok, got.eval_ok);
            fail_count++;
          end
          if (got.has_value !== exp_res.has_value) begin
            $display("%0t: has_value expected %b actual %b", $time,
                     exp_res.has_value, got.has_value);
            fail_count++;
          end
        end
      end
    end
  end

  initial fail_count = 0;
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pse_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int RandomTokens = 950;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // req_type, operand_value, op_code, pad
  logic        s_axis_tlast;   // last_token
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // result_value, eval_ok, has_value, pad
  int          fail_count;
  int          results_pending;
  int          cycle_count;
  int          tokens_sent;

  postfix_stack_evaluator_top u_top (.*);

  pse_result_checker u_checker (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .fail_count, .results_pending
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL postfix_stack_evaluator_top");
      $finish;
    end
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5, 6: return 32'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_token(logic req, logic [31:0] val, op_t op, logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, op, val, req};
    s_axis_tlast <= last;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    if (op != OP_NONE || !req) tokens_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 40'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_op(logic [31:0] val);
    send_token(1'b0, val, op_t'($urandom_range(0, 15)), 1'b0);
  endtask

  task automatic apply(op_t op, logic last);
    send_token(1'b1, $urandom, op, last);
  endtask

  // Receiver: random stalls, plus one long hold-off to back up the block
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    repeat (2000) begin
      @(posedge clk);
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
    @(posedge clk);
    m_axis_tready <= 1'b0;
    repeat (3000) @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 30)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if ($urandom_range(0, 3) == 0) @(posedge clk);
    end
  end

  initial begin
    int len, depth;
    logic [31:0] chain_vals [15];
    op_t chain_ops [15];
    cycle_count = 0;
    tokens_sent = 0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Chain every operator across extreme operands
    chain_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd3, 32'hFFFF_FFFE, 32'd5,
                   32'd7, 32'hFFFF_FFFF, 32'd0, 32'd2, 32'd1, 32'd9, 32'd1,
                   32'd0, 32'd4, 32'd0};
    chain_ops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW, OP_MOD, OP_GT, OP_LT,
                  OP_GE, OP_LE, OP_NE, OP_EQ, OP_NOT, OP_AND, OP_OR};
    push_op(32'hFFFF_FFF9);
    for (int i = 0; i < 15; i++) begin
      if (chain_ops[i] != OP_NOT) push_op(chain_vals[i]);
      apply(chain_ops[i], i == 14);
    end
    // Zero divisor, zero modulus, most negative over minus one
    push_op(32'd5); push_op(32'd0); apply(OP_DIV, 1'b1);
    push_op(32'd5); push_op(32'd0); apply(OP_MOD, 1'b1);
    push_op(32'h8000_0000); push_op(32'hFFFF_FFFF); apply(OP_DIV, 1'b0);
    push_op(32'h8000_0000); push_op(32'hFFFF_FFFF); apply(OP_MOD, 1'b1);
    // Negative exponents, zero base, empty pops, unused opcode
    push_op(32'hFFFF_FFFF); push_op(32'hFFFF_FFFD); apply(OP_POW, 1'b0);
    push_op(32'd0); push_op(32'hFFFF_FFFF); apply(OP_POW, 1'b1);
    push_op(32'd1); push_op(32'h8000_0000); apply(OP_POW, 1'b0);
    push_op(32'd2); push_op(32'hFFFF_FFFF); apply(OP_POW, 1'b1);
    apply(OP_NONE, 1'b0); apply(OP_SUB, 1'b0); apply(OP_NOT, 1'b1);
    apply(OP_NONE, 1'b1);

    // Random expressions, mostly well formed
    tokens_sent = 0;
    while (tokens_sent < RandomTokens) begin
      if ($urandom_range(0, 29) == 0) begin
        // Push 62 to 67 operands, often overfilling the stack
        repeat ($urandom_range(62, 67)) push_op(pick_value());
        apply(op_t'($urandom_range(0, 14)), 1'b1);
      end else begin
        len = $urandom_range(1, 9);
        depth = 0;
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_token(1'($urandom_range(0, 1)), pick_value(),
                       op_t'($urandom_range(0, 15)), k == len - 1);
          end else if (depth < 2 && !(depth == 1 && $urandom_range(0, 3) == 0)) begin
            send_token(1'b0, pick_value(), op_t'($urandom_range(0, 15)),
                       k == len - 1);
            depth++;
          end else if ($urandom_range(0, 2) == 0) begin
            send_token(1'b0, pick_value(), op_t'($urandom_range(0, 15)),
                       k == len - 1);
            depth++;
          end else begin
            if (depth == 1) begin
              apply(OP_NOT, k == len - 1);
            end else begin
              apply(op_t'($urandom_range(0, 14)), k == len - 1);
              depth--;
            end
          end
        end
      end
    end

    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    while (results_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS postfix_stack_evaluator_top");
    end else begin
      $display("FAIL postfix_stack_evaluator_top");
    end
    $finish;
  end
endmodule
`default_nettype wire
